@@ hw/rtl/itda_pkg.sv @@
package itda_pkg;

  localparam int VALUE_W    = 64;
  localparam int NUM_DIGITS = 20;
  localparam int DIGIT_W    = 4;
  localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
  localparam int CHAR_W     = 6;
  localparam int CNT_W      = $clog2(VALUE_W);
  localparam int NDIG_W     = $clog2(NUM_DIGITS + 1);
  localparam int POS_W      = $clog2(NUM_DIGITS);

  localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0]  CHAR_MINUS = 6'd45;
  localparam logic [CNT_W-1:0]   CNT_LAST   = CNT_W'(VALUE_W - 1);
  localparam logic [NDIG_W-1:0]  NDIG_MAX   = NDIG_W'(NUM_DIGITS);
  localparam logic [DIGIT_W-1:0] DIGIT_FIX  = 4'd5;
  localparam logic [DIGIT_W-1:0] DIGIT_ADD  = 4'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_t;

endpackage

@@ hw/rtl/itda_if.sv @@
interface itda_in_if;
  logic                           valid;
  logic                           ready;
  logic [itda_pkg::VALUE_W-1:0]   value_bits;
  logic                           is_signed;

  modport source (output valid, output value_bits, output is_signed, input ready);
  modport sink   (input valid, input value_bits, input is_signed, output ready);
endinterface

interface itda_out_if;
  logic                           valid;
  logic                           ready;
  logic [itda_pkg::CHAR_W-1:0]    text_char;
  logic                           last_char;

  modport source (output valid, output text_char, output last_char, input ready);
  modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

@@ hw/rtl/int_to_decimal_ascii.sv @@
// int_to_decimal_ascii: prints a 64-bit value as decimal ascii text.
// in_bus carries value_bits and is_signed; a beat is taken when valid and
// ready are both high. is_signed set with bit 63 set means a negative
// two's complement value, which is printed as '-' and its magnitude.
// out_bus sends one character per beat, most significant digit first, and
// raises last_char on the final digit. Zero prints as the single '0'.
// Timing: after the input beat the magnitude is shifted one bit per cycle
// through a 20-digit bcd register with add-3 correction. The characters
// then leave one per cycle while the receiver is ready, 1 to 20 of them.
// One number is handled at a time.
// in_bus.ready is high only while the block is idle; it may take the next
// number while the final character of the previous one still waits in the
// output register. When the receiver stalls, the output register holds its
// character and the block waits with it; nothing is dropped.
// Reset (rst_n low, synchronous) returns to idle and empties the output
// register; no number in flight survives it.
module int_to_decimal_ascii (
  input  logic           clk,
  input  logic           rst_n,
  itda_in_if.sink        in_bus,
  itda_out_if.source     out_bus
);

  itda_pkg::state_t                      state_r, state_nxt;
  logic [itda_pkg::VALUE_W-1:0]          mag_r, mag_nxt;
  logic [itda_pkg::BCD_W-1:0]            bcd_r, bcd_nxt;
  logic [itda_pkg::CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [itda_pkg::NDIG_W-1:0]           ndig_r, ndig_nxt;
  logic [itda_pkg::POS_W-1:0]            pos_r, pos_nxt;
  logic                                  neg_r, neg_nxt;
  logic                                  out_valid_r, out_valid_nxt;
  logic [itda_pkg::CHAR_W-1:0]           out_char_r, out_char_nxt;
  logic                                  out_last_r, out_last_nxt;

  logic                                  in_take;
  logic                                  out_free;
  logic                                  load_char;
  logic                                  in_neg;
  logic [itda_pkg::BCD_W-1:0]            bcd_adj;
  logic [itda_pkg::BCD_W-1:0]            bcd_shift;
  logic [itda_pkg::DIGIT_W-1:0]          dig_sh [itda_pkg::NUM_DIGITS];
  logic [itda_pkg::DIGIT_W-1:0]          dig_cur [itda_pkg::NUM_DIGITS];
  logic                                  grow;
  logic [itda_pkg::NDIG_W-1:0]           ndig_fin;

  assign in_take   = in_bus.valid && in_bus.ready;
  assign out_free  = !out_valid_r || out_bus.ready;
  assign load_char = (state_r == itda_pkg::ST_EMIT) && out_free;
  assign in_neg    = in_bus.is_signed && in_bus.value_bits[itda_pkg::VALUE_W-1];

  // add-3 on every digit of five or more, then shift in the next bit
  always_comb begin
    for (int i = 0; i < itda_pkg::NUM_DIGITS; i++) begin
      if (bcd_r[i*itda_pkg::DIGIT_W +: itda_pkg::DIGIT_W] >= itda_pkg::DIGIT_FIX) begin
        bcd_adj[i*itda_pkg::DIGIT_W +: itda_pkg::DIGIT_W] =
          bcd_r[i*itda_pkg::DIGIT_W +: itda_pkg::DIGIT_W] + itda_pkg::DIGIT_ADD;
      end else begin
        bcd_adj[i*itda_pkg::DIGIT_W +: itda_pkg::DIGIT_W] =
          bcd_r[i*itda_pkg::DIGIT_W +: itda_pkg::DIGIT_W];
      end
    end
  end

  assign bcd_shift = {bcd_adj[itda_pkg::BCD_W-2:0], mag_r[itda_pkg::VALUE_W-1]};

  always_comb begin
    for (int i = 0; i < itda_pkg::NUM_DIGITS; i++) begin
      dig_sh[i]  = bcd_shift[i*itda_pkg::DIGIT_W +: itda_pkg::DIGIT_W];
      dig_cur[i] = bcd_r[i*itda_pkg::DIGIT_W +: itda_pkg::DIGIT_W];
    end
  end

  // doubling plus one bit adds at most one digit, so only the digit just
  // above the current length needs a look
  assign grow = (ndig_r < itda_pkg::NDIG_MAX) &&
                (dig_sh[ndig_r[itda_pkg::POS_W-1:0]] != '0);
  assign ndig_fin = grow ? ndig_r + itda_pkg::NDIG_W'(1) : ndig_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      itda_pkg::ST_IDLE: begin
        if (in_take) begin
          state_nxt = itda_pkg::ST_CONV;
        end
      end
      itda_pkg::ST_CONV: begin
        if (cnt_r == itda_pkg::CNT_LAST) begin
          state_nxt = itda_pkg::ST_EMIT;
        end
      end
      itda_pkg::ST_EMIT: begin
        if (load_char && !neg_r && pos_r == '0) begin
          state_nxt = itda_pkg::ST_IDLE;
        end
      end
      default: state_nxt = itda_pkg::ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_bus.ready = (state_r == itda_pkg::ST_IDLE);
  end

  // datapath
  always_comb begin
    mag_nxt       = mag_r;
    bcd_nxt       = bcd_r;
    cnt_nxt       = cnt_r;
    ndig_nxt      = ndig_r;
    pos_nxt       = pos_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_valid_r && !out_bus.ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;

    if (in_take) begin
      mag_nxt  = in_neg ? (~in_bus.value_bits + itda_pkg::VALUE_W'(1)) : in_bus.value_bits;
      bcd_nxt  = '0;
      cnt_nxt  = '0;
      ndig_nxt = '0;
      neg_nxt  = in_neg;
    end else if (state_r == itda_pkg::ST_CONV) begin
      mag_nxt  = {mag_r[itda_pkg::VALUE_W-2:0], 1'b0};
      bcd_nxt  = bcd_shift;
      cnt_nxt  = cnt_r + itda_pkg::CNT_W'(1);
      ndig_nxt = ndig_fin;
      // zero still prints one digit
      if (ndig_fin == '0) begin
        pos_nxt = '0;
      end else begin
        pos_nxt = itda_pkg::POS_W'(ndig_fin - itda_pkg::NDIG_W'(1));
      end
    end

    if (load_char) begin
      out_valid_nxt = 1'b1;
      if (neg_r) begin
        out_char_nxt = itda_pkg::CHAR_MINUS;
        out_last_nxt = 1'b0;
        neg_nxt      = 1'b0;
      end else begin
        out_char_nxt = itda_pkg::CHAR_ZERO + itda_pkg::CHAR_W'(dig_cur[pos_r]);
        out_last_nxt = (pos_r == '0);
        if (pos_r != '0) begin
          pos_nxt = pos_r - itda_pkg::POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= itda_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      neg_r       <= 1'b0;
      cnt_r       <= '0;
      ndig_r      <= '0;
      pos_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      neg_r       <= neg_nxt;
      cnt_r       <= cnt_nxt;
      ndig_r      <= ndig_nxt;
      pos_r       <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    bcd_r      <= bcd_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_bus.valid     = out_valid_r;
  assign out_bus.text_char = out_char_r;
  assign out_bus.last_char = out_last_r;

`ifndef SYNTHESIS
  a_new_char_only_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r && !out_bus.ready)) |->
      $past(state_r) == itda_pkg::ST_EMIT)
    else $error("character appeared outside emit phase");

  a_ndig_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    ndig_r <= itda_pkg::NDIG_MAX)
    else $error("digit count above twenty");

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_char_r == itda_pkg::CHAR_MINUS) |-> !out_last_r)
    else $error("minus sign marked as last character");

  a_conv_length: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == itda_pkg::ST_CONV && cnt_r == itda_pkg::CNT_LAST) |=>
      state_r == itda_pkg::ST_EMIT)
    else $error("conversion did not end after 64 bits");
`endif

endmodule

@@ dv/int_to_decimal_ascii_test.sv @@
module int_to_decimal_ascii_test;

  localparam int NUM_RANDOM   = 150;
  localparam int STALL_PCT    = 11;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 100;

  typedef struct {
    logic [itda_pkg::CHAR_W-1:0] text_char;
    logic                        last_char;
  } text_beat_t;

  // expected characters still to be checked, of every number accepted so far, oldest first
  class decimal_text_board;
    text_beat_t pending_chars[$];
    int         mismatches;
    int         chars_checked;
    int         numbers_seen;
    int         negatives_seen;

    function new();
      mismatches     = 0;
      chars_checked  = 0;
      numbers_seen   = 0;
      negatives_seen = 0;
    endfunction

    function void note_number(logic [itda_pkg::VALUE_W-1:0] raw, logic as_signed);
      logic [itda_pkg::VALUE_W-1:0] mag;
      logic [itda_pkg::DIGIT_W-1:0] digits[$];
      text_beat_t                   beat;
      bit                           neg;
      neg = as_signed && raw[itda_pkg::VALUE_W-1];
      // exact even for the most negative value
      mag = neg ? (~raw + 64'd1) : raw;
      do begin
        digits.push_front(itda_pkg::DIGIT_W'(mag % 64'd10));
        mag = mag / 64'd10;
      end while (mag != 0);
      if (neg) begin
        beat.text_char = itda_pkg::CHAR_MINUS;
        beat.last_char = 1'b0;
        pending_chars.push_back(beat);
        negatives_seen++;
      end
      foreach (digits[i]) begin
        beat.text_char = itda_pkg::CHAR_ZERO + itda_pkg::CHAR_W'(digits[i]);
        beat.last_char = (i == digits.size() - 1);
        pending_chars.push_back(beat);
      end
      numbers_seen++;
    endfunction

    function void check_char(logic [itda_pkg::CHAR_W-1:0] got_char, logic got_last);
      text_beat_t want;
      if (pending_chars.size() == 0) begin
        $error("unexpected character beat: text_char %0d last_char %0d", got_char, got_last);
        mismatches++;
        return;
      end
      want = pending_chars.pop_front();
      chars_checked++;
      if (got_char !== want.text_char) begin
        $error("text_char: expected %0d, got %0d", want.text_char, got_char);
        mismatches++;
      end
      if (got_last !== want.last_char) begin
        $error("last_char: expected %0d, got %0d", want.last_char, got_last);
        mismatches++;
      end
    endfunction

    function int outstanding();
      return pending_chars.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   no_gaps;
  int   quiet_cycles;
  decimal_text_board board;

  itda_in_if  in_ch();
  itda_out_if out_ch();

  int_to_decimal_ascii dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_ch),
    .out_bus(out_ch)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver: check each beat, then decide whether to stall next cycle
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      board.check_char(out_ch.text_char, out_ch.last_char);
    end
    out_ch.ready <= no_gaps || ($urandom_range(99) >= STALL_PCT);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
      $display("[int_to_decimal_ascii] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // valid is lowered only for random idle gaps before a beat, and never while no_gaps is set
  task automatic send_number(input logic [itda_pkg::VALUE_W-1:0] raw,
                             input logic as_signed);
    if (!no_gaps && $urandom_range(99) < STALL_PCT) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < STALL_PCT);
    end
    in_ch.valid      <= 1'b1;
    in_ch.value_bits <= raw;
    in_ch.is_signed  <= as_signed;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.note_number(raw, as_signed);
  endtask

  function automatic logic [itda_pkg::VALUE_W-1:0] pick_number(output logic as_signed);
    logic [itda_pkg::VALUE_W-1:0] v;
    logic [itda_pkg::VALUE_W-1:0] pow;
    int                           width;
    v         = {$urandom, $urandom};
    as_signed = 1'($urandom_range(1));
    case ($urandom_range(3))
      0: ;
      1: begin
        width = $urandom_range(1, itda_pkg::VALUE_W);
        v     = v & ({itda_pkg::VALUE_W{1'b1}} >> (itda_pkg::VALUE_W - width));
      end
      2: begin
        // near a power of ten, where the digit count changes
        pow = 64'd1;
        repeat ($urandom_range(itda_pkg::NUM_DIGITS - 1)) pow = pow * 64'd10;
        v = pow + 64'($urandom_range(2)) - 64'd1;
      end
      default: begin
        width     = $urandom_range(1, itda_pkg::VALUE_W - 1);
        v         = -(v & ({itda_pkg::VALUE_W{1'b1}} >> (itda_pkg::VALUE_W - width)));
        as_signed = 1'b1;
      end
    endcase
    return v;
  endfunction

  initial begin
    logic [itda_pkg::VALUE_W-1:0] raw;
    logic                         as_signed;
    int                           directed;
    board            = new();
    no_gaps          = 1'b0;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.value_bits = '0;
    in_ch.is_signed  = 1'b0;
    out_ch.ready     = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_number(64'd0, 1'b0);
    send_number(64'd0, 1'b1);
    send_number(64'd1, 1'b0);
    send_number(64'd9, 1'b1);
    send_number(64'd10, 1'b0);
    send_number(64'd99, 1'b1);
    send_number(64'd100, 1'b0);
    send_number(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    send_number(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    send_number(64'h8000_0000_0000_0000, 1'b1);
    send_number(64'h8000_0000_0000_0000, 1'b0);
    send_number(64'h7FFF_FFFF_FFFF_FFFF, 1'b1);
    send_number(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
    send_number(64'd10000000000000000000, 1'b0);
    send_number(64'd9999999999999999999, 1'b0);
    send_number(64'hFFFF_FFFF_FFFF_FFF6, 1'b1);
    send_number(64'h5555_5555_5555_5555, 1'b0);
    send_number(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
    send_number(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    send_number(64'd1000000000, 1'b1);
    directed = board.numbers_seen;

    for (int n = 0; n < NUM_RANDOM; n++) begin
      no_gaps = (n >= 70 && n < 110);
      raw     = pick_number(as_signed);
      send_number(raw, as_signed);
    end
    no_gaps = 1'b0;
    in_ch.valid <= 1'b0;

    while (board.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("formatted %0d numbers (%0d directed, %0d negative), %0d characters checked",
             board.numbers_seen, directed, board.negatives_seen, board.chars_checked);
    if (board.mismatches == 0) begin
      $display("[int_to_decimal_ascii] OK");
    end else begin
      $display("[int_to_decimal_ascii] ERROR");
    end
    $finish;
  end

endmodule
